/* hdl/knt_pkg.sv */
// Package for the keyed node table: operation and status codes, register
// indexes and the transaction and entry types.
// No dependencies.
package knt_pkg;

    localparam logic [2:0] FN_SET_ALL  = 3'd0;
    localparam logic [2:0] FN_SET_PROF = 3'd1;
    localparam logic [2:0] FN_SET_VER  = 3'd2;
    localparam logic [2:0] FN_LOOKUP   = 3'd3;
    localparam logic [2:0] FN_REMOVE   = 3'd4;
    localparam logic [2:0] FN_CLEAR    = 3'd5;

    localparam logic [3:0] ST_UPDATED   = 4'd0;
    localparam logic [3:0] ST_UNCHANGED = 4'd1;
    localparam logic [3:0] ST_APPENDED  = 4'd2;
    localparam logic [3:0] ST_DROPPED   = 4'd3;
    localparam logic [3:0] ST_RESERVED  = 4'd4;
    localparam logic [3:0] ST_FOUND     = 4'd5;
    localparam logic [3:0] ST_NOT_FOUND = 4'd6;
    localparam logic [3:0] ST_REMOVED   = 4'd7;
    localparam logic [3:0] ST_CLEARED   = 4'd8;

    localparam int          CFG_IDX_W        = 2;
    localparam int          CFG_DATA_W       = 8;
    localparam logic [1:0] CFG_UNKNOWN_ID   = 2'd0;
    localparam logic [1:0] CFG_BROADCAST_ID = 2'd1;
    localparam logic [1:0] CFG_FALLBACK     = 2'd2;

    localparam logic [7:0] UNKNOWN_ID_RST   = 8'd0;
    localparam logic [7:0] BROADCAST_ID_RST = 8'd255;
    localparam logic [7:0] FALLBACK_RST     = 8'd0;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] node_key;
        logic [7:0] profile_in;
        logic [7:0] major_in;
        logic [7:0] minor_in;
        logic [7:0] patch_in;
    } t_req;

    typedef struct packed {
        logic [3:0] status;
        logic [7:0] profile_out;
        logic [7:0] major_out;
        logic [7:0] minor_out;
        logic [7:0] patch_out;
        logic [4:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  key;
        logic [7:0]  profile;
        logic [23:0] version;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic shift;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic scan_done;
        logic do_shift;
        logic shift_done;
    } t_stat;

endpackage

/* hdl/knt_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on knt_pkg.
interface knt_req_if;
    logic          valid;
    logic          ready;
    knt_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface knt_rsp_if;
    logic          valid;
    logic          ready;
    knt_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/knt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module knt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/knt_ctrl.sv */
// Controller for the keyed node table: sequences scan, decide, shift and
// result hand-over, and owns the channel handshakes.
// Depends on knt_pkg.
module knt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output knt_pkg::t_cmd o_cmd,
    input  knt_pkg::t_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   room;

    assign room = !r_out_vld || i_out_ready;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_out_vld = r_out_vld && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.skip || i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.do_shift ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.shift_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (room) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

/* hdl/knt_dp.sv */
// Datapath for the keyed node table: entry RAM, fill count, scan and shift
// address counters, operation decision, configuration and response registers.
// Depends on knt_pkg and knt_ram.
module knt_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  knt_pkg::t_cmd                   i_cmd,
    output knt_pkg::t_stat                  o_stat,
    input  knt_pkg::t_req                   i_req_data,
    output knt_pkg::t_rsp                   o_rsp_data,
    input  logic                            i_cfg_we,
    input  logic [knt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [knt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam int EW = $bits(knt_pkg::t_entry);

    logic [7:0] r_cfg_unk, r_cfg_bc, r_cfg_fb;

    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   r_idx;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_pidx;
    logic            r_hit;
    logic [AW-1:0]   r_pos;
    knt_pkg::t_entry r_hit_ent;
    knt_pkg::t_req   r_item;

    logic [3:0]  r_res_status, n_res_status;
    logic [7:0]  r_res_prof, n_res_prof;
    logic [23:0] r_res_ver, n_res_ver;
    knt_pkg::t_rsp r_rsp;

    knt_pkg::t_entry rd_ent, wr_ent, dec_ent;
    logic [EW-1:0]   rd_raw;
    logic            we, dec_we;
    logic [AW-1:0]   waddr, dec_addr;
    logic            in_range, hit_now, issue, is_set, rsv;
    logic            same_p, same_v, same, do_shift;
    logic [23:0]     item_ver;

    knt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_ent),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_raw)
    );

    assign rd_ent   = knt_pkg::t_entry'(rd_raw);
    assign item_ver = {r_item.major_in, r_item.minor_in, r_item.patch_in};
    assign in_range = (r_idx < r_fill);
    assign is_set   = r_item.func inside {knt_pkg::FN_SET_ALL, knt_pkg::FN_SET_PROF,
                                          knt_pkg::FN_SET_VER};
    assign rsv      = (r_item.node_key == r_cfg_unk) || (r_item.node_key == r_cfg_bc);
    assign hit_now  = i_cmd.scan && r_pend && (rd_ent.key == r_item.node_key);
    assign issue    = ((i_cmd.scan && !o_stat.skip && !hit_now) || i_cmd.shift) && in_range;
    assign n_pend   = issue;

    assign o_stat.skip       = (is_set && rsv) || (r_item.func > knt_pkg::FN_REMOVE);
    assign o_stat.scan_done  = hit_now || (!r_pend && !in_range);
    assign o_stat.shift_done = !r_pend && !in_range;
    assign o_stat.do_shift   = do_shift;

    assign same_p = (r_hit_ent.profile == r_item.profile_in);
    assign same_v = (r_hit_ent.version == item_ver);

    always_comb begin
        case (r_item.func)
            knt_pkg::FN_SET_ALL:  same = same_p && same_v;
            knt_pkg::FN_SET_PROF: same = same_p;
            default:              same = same_v;
        endcase
    end

    always_comb begin
        n_res_status = knt_pkg::ST_UNCHANGED;
        n_res_prof   = '0;
        n_res_ver    = '0;
        dec_we       = 1'b0;
        dec_addr     = r_pos;
        dec_ent      = r_hit_ent;
        do_shift     = 1'b0;
        n_fill       = r_fill;
        case (r_item.func)
            knt_pkg::FN_SET_ALL, knt_pkg::FN_SET_PROF, knt_pkg::FN_SET_VER: begin
                if (rsv) begin
                    n_res_status = knt_pkg::ST_RESERVED;
                end else if (r_hit) begin
                    if (!same) begin
                        dec_we       = 1'b1;
                        n_res_status = knt_pkg::ST_UPDATED;
                        if (r_item.func != knt_pkg::FN_SET_VER) begin
                            dec_ent.profile = r_item.profile_in;
                        end
                        if (r_item.func != knt_pkg::FN_SET_PROF) begin
                            dec_ent.version = item_ver;
                        end
                    end
                end else if (r_fill < DEPTH_C) begin
                    dec_we       = 1'b1;
                    dec_addr     = r_fill[AW-1:0];
                    dec_ent.key  = r_item.node_key;
                    dec_ent.profile = (r_item.func == knt_pkg::FN_SET_VER) ?
                                      8'd0 : r_item.profile_in;
                    dec_ent.version = (r_item.func == knt_pkg::FN_SET_PROF) ?
                                      24'd0 : item_ver;
                    n_fill       = r_fill + CW'(1);
                    n_res_status = knt_pkg::ST_APPENDED;
                end else begin
                    n_res_status = knt_pkg::ST_DROPPED;
                end
            end
            knt_pkg::FN_LOOKUP: begin
                if (r_hit) begin
                    n_res_status = knt_pkg::ST_FOUND;
                    n_res_prof   = r_hit_ent.profile;
                    n_res_ver    = r_hit_ent.version;
                end else begin
                    n_res_status = knt_pkg::ST_NOT_FOUND;
                    n_res_prof   = r_cfg_fb;
                end
            end
            knt_pkg::FN_REMOVE: begin
                if (r_hit) begin
                    n_res_status = knt_pkg::ST_REMOVED;
                    do_shift     = 1'b1;
                end else begin
                    n_res_status = knt_pkg::ST_NOT_FOUND;
                end
            end
            knt_pkg::FN_CLEAR: begin
                n_res_status = knt_pkg::ST_CLEARED;
                n_fill       = '0;
            end
            default: begin
                n_res_status = knt_pkg::ST_UNCHANGED;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.shift) begin
            we     = r_pend;
            waddr  = r_pidx - AW'(1);
            wr_ent = rd_ent;
        end else begin
            we     = i_cmd.decide && dec_we;
            waddr  = dec_addr;
            wr_ent = dec_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_unk <= knt_pkg::UNKNOWN_ID_RST;
            r_cfg_bc  <= knt_pkg::BROADCAST_ID_RST;
            r_cfg_fb  <= knt_pkg::FALLBACK_RST;
            r_fill    <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    knt_pkg::CFG_UNKNOWN_ID:   r_cfg_unk <= i_cfg_wdata;
                    knt_pkg::CFG_BROADCAST_ID: r_cfg_bc  <= i_cfg_wdata;
                    knt_pkg::CFG_FALLBACK:     r_cfg_fb  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.decide) begin
                r_fill <= n_fill;
            end else if (i_cmd.shift && o_stat.shift_done) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_req_data;
            r_idx  <= '0;
            r_hit  <= 1'b0;
        end else if (i_cmd.decide) begin
            r_idx <= CW'(r_pos) + CW'(1);
        end else if (issue) begin
            r_idx <= r_idx + CW'(1);
        end
        if (issue) begin
            r_pidx <= r_idx[AW-1:0];
        end
        if (hit_now) begin
            r_hit     <= 1'b1;
            r_pos     <= r_pidx;
            r_hit_ent <= rd_ent;
        end
        if (i_cmd.decide) begin
            r_res_status <= n_res_status;
            r_res_prof   <= n_res_prof;
            r_res_ver    <= n_res_ver;
        end
        if (i_cmd.out_load) begin
            r_rsp.status      <= r_res_status;
            r_rsp.profile_out <= r_res_prof;
            r_rsp.major_out   <= r_res_ver[23:16];
            r_rsp.minor_out   <= r_res_ver[15:8];
            r_rsp.patch_out   <= r_res_ver[7:0];
            r_rsp.entry_count <= 5'(r_fill);
        end
    end

    assign o_rsp_data = r_rsp;

endmodule

/* hdl/keyed_node_table_top.sv */
// Top level of the keyed node table: joins controller and datapath to the
// request, response and configuration ports.
// Depends on knt_pkg, knt_if, knt_ctrl and knt_dp.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  i_req    | in        | valid/ready         | func, key, profile, version
//  o_rsp    | out       | valid/ready         | status, profile, version, count
//  i_cfg_*  | in        | write enable only   | register index, 8-bit data
//
// One transaction: accept, a scan through the RAM read port, decide and hand-over. The scan
// ends on a hit, at the fill count on a miss, or at once when the table is empty or no search
// is needed. A remove adds a shift pass that moves any later entries down and lowers the fill.
// Hand-over waits while the previous response is unread; one transaction is in flight.
// Synchronous reset empties the table and restores the registers; no RAM clearing pass.
module keyed_node_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    knt_req_if.sink                        i_req,
    knt_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [knt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [knt_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    knt_pkg::t_cmd  cmd;
    knt_pkg::t_stat stat;
    logic           in_ready;
    logic           out_valid;
    knt_pkg::t_rsp  rsp_data;

    knt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    knt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_req_data  (i_req.data),
        .o_rsp_data  (rsp_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp_data;

endmodule

/* verif/keyed_node_table_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for keyed_node_table_top: queued request transactions,
// a predicting table model and a response checker on the valid/ready channels.
// Depends on knt_pkg, knt_if and the keyed_node_table_top RTL.
module keyed_node_table_top_tb;

    localparam int         DEPTH       = 16;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         REPORT_MAX  = 10;
    localparam logic [2:0] FN_SPARE_6  = 3'd6;
    localparam logic [2:0] FN_SPARE_7  = 3'd7;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [knt_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [knt_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    knt_req_if req_ch ();
    knt_rsp_if rsp_ch ();

    keyed_node_table_top #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [7:0]  tbl_key [DEPTH];
    logic [7:0]  tbl_prof[DEPTH];
    logic [23:0] tbl_ver [DEPTH];
    int          tbl_fill;
    logic [7:0]  cfg_unknown;
    logic [7:0]  cfg_broadcast;
    logic [7:0]  cfg_fallback;
    logic [7:0]  key_base;

    knt_pkg::t_req req_pending[$];
    knt_pkg::t_rsp rsp_expected[$];

    bit req_fire;
    bit rsp_fire;
    bit req_calm;
    bit rsp_calm;
    int req_gap;
    int rsp_stall;
    int mismatches;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic knt_pkg::t_rsp table_predict(knt_pkg::t_req rq);
        knt_pkg::t_rsp rs;
        int            pos;
        int            i;
        logic [23:0]   ver;
        logic          same;
        rs        = '0;
        rs.status = knt_pkg::ST_UNCHANGED;
        ver       = {rq.major_in, rq.minor_in, rq.patch_in};
        pos       = -1;
        for (i = 0; i < tbl_fill; i++) begin
            if (pos < 0 && tbl_key[i] == rq.node_key) begin
                pos = i;
            end
        end
        case (rq.func)
            knt_pkg::FN_SET_ALL, knt_pkg::FN_SET_PROF, knt_pkg::FN_SET_VER: begin
                if (rq.node_key == cfg_unknown || rq.node_key == cfg_broadcast) begin
                    rs.status = knt_pkg::ST_RESERVED;
                end else if (pos >= 0) begin
                    if (rq.func == knt_pkg::FN_SET_ALL) begin
                        same = (tbl_prof[pos] == rq.profile_in) && (tbl_ver[pos] == ver);
                    end else if (rq.func == knt_pkg::FN_SET_PROF) begin
                        same = tbl_prof[pos] == rq.profile_in;
                    end else begin
                        same = tbl_ver[pos] == ver;
                    end
                    if (same) begin
                        rs.status = knt_pkg::ST_UNCHANGED;
                    end else begin
                        if (rq.func != knt_pkg::FN_SET_VER) begin
                            tbl_prof[pos] = rq.profile_in;
                        end
                        if (rq.func != knt_pkg::FN_SET_PROF) begin
                            tbl_ver[pos] = ver;
                        end
                        rs.status = knt_pkg::ST_UPDATED;
                    end
                end else if (tbl_fill < DEPTH) begin
                    tbl_key[tbl_fill]  = rq.node_key;
                    tbl_prof[tbl_fill] = (rq.func == knt_pkg::FN_SET_VER) ?
                                         8'h00 : rq.profile_in;
                    tbl_ver[tbl_fill]  = (rq.func == knt_pkg::FN_SET_PROF) ?
                                         24'h0 : ver;
                    tbl_fill++;
                    rs.status = knt_pkg::ST_APPENDED;
                end else begin
                    rs.status = knt_pkg::ST_DROPPED;
                end
            end
            knt_pkg::FN_LOOKUP: begin
                if (pos >= 0) begin
                    rs.status      = knt_pkg::ST_FOUND;
                    rs.profile_out = tbl_prof[pos];
                    {rs.major_out, rs.minor_out, rs.patch_out} = tbl_ver[pos];
                end else begin
                    rs.status      = knt_pkg::ST_NOT_FOUND;
                    rs.profile_out = cfg_fallback;
                end
            end
            knt_pkg::FN_REMOVE: begin
                if (pos >= 0) begin
                    for (i = pos; i + 1 < tbl_fill; i++) begin
                        tbl_key[i]  = tbl_key[i + 1];
                        tbl_prof[i] = tbl_prof[i + 1];
                        tbl_ver[i]  = tbl_ver[i + 1];
                    end
                    tbl_fill--;
                    rs.status = knt_pkg::ST_REMOVED;
                end else begin
                    rs.status = knt_pkg::ST_NOT_FOUND;
                end
            end
            knt_pkg::FN_CLEAR: begin
                tbl_fill  = 0;
                rs.status = knt_pkg::ST_CLEARED;
            end
            default: begin
                rs.status = knt_pkg::ST_UNCHANGED;
            end
        endcase
        rs.entry_count = tbl_fill[4:0];
        return rs;
    endfunction

    task automatic check_rsp(knt_pkg::t_rsp want, knt_pkg::t_rsp got);
        if (got.status !== want.status || got.profile_out !== want.profile_out ||
            got.major_out !== want.major_out || got.minor_out !== want.minor_out ||
            got.patch_out !== want.patch_out || got.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("mismatch: st %0d/%0d prof %h/%h ver %h%h%h/%h%h%h cnt %0d/%0d",
                         want.status, got.status, want.profile_out, got.profile_out,
                         want.major_out, want.minor_out, want.patch_out,
                         got.major_out, got.minor_out, got.patch_out,
                         want.entry_count, got.entry_count);
            end
        end
    endtask

    // Driver: record accepted transactions, then present the next one after its gap
    always @(posedge i_clk) begin
        req_fire = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
        if (req_fire) begin
            rsp_expected = {rsp_expected, table_predict(req_ch.data)};
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_fire) begin
            if (req_gap > 0) begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end else if (req_pending.size() != 0) begin
                req_ch.data  <= req_pending.pop_front();
                req_ch.valid <= 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    req_calm = !req_calm;
                end
                req_gap = req_calm ? 0 : $urandom_range(0, 3);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each response transaction with the oldest prediction
    always @(posedge i_clk) begin
        rsp_fire = (rsp_ch.valid === 1'b1) && (rsp_ch.ready === 1'b1);
        if (rsp_fire) begin
            if (rsp_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected response: status %0d count %0d",
                             rsp_ch.data.status, rsp_ch.data.entry_count);
                end
            end else begin
                check_rsp(rsp_expected.pop_front(), rsp_ch.data);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_fire) begin
                if ($urandom_range(0, 39) == 0) begin
                    rsp_calm = !rsp_calm;
                end
                rsp_stall = rsp_calm ? 0 : $urandom_range(0, 3);
            end
            if (rsp_ch.valid === 1'b1) begin
                if (rsp_stall > 0) begin
                    rsp_stall--;
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                end
            end else begin
                rsp_ch.ready <= rsp_calm ? 1'b1 : 1'($urandom_range(0, 1));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic queue_req(logic [2:0] func, logic [7:0] key, logic [7:0] prof,
                             logic [7:0] maj, logic [7:0] mnr, logic [7:0] pat);
        knt_pkg::t_req rq;
        rq.func       = func;
        rq.node_key   = key;
        rq.profile_in = prof;
        rq.major_in   = maj;
        rq.minor_in   = mnr;
        rq.patch_in   = pat;
        req_pending   = {req_pending, rq};
    endtask

    task automatic write_reg(logic [knt_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        case (idx)
            knt_pkg::CFG_UNKNOWN_ID:   cfg_unknown   = value;
            knt_pkg::CFG_BROADCAST_ID: cfg_broadcast = value;
            knt_pkg::CFG_FALLBACK:     cfg_fallback  = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (req_pending.size() != 0 || req_ch.valid || rsp_expected.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [2:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)      return knt_pkg::FN_SET_ALL;
        else if (r < 34) return knt_pkg::FN_SET_PROF;
        else if (r < 50) return knt_pkg::FN_SET_VER;
        else if (r < 73) return knt_pkg::FN_LOOKUP;
        else if (r < 93) return knt_pkg::FN_REMOVE;
        else if (r < 95) return knt_pkg::FN_CLEAR;
        else if (r < 98) return FN_SPARE_6;
        else             return FN_SPARE_7;
    endfunction

    function automatic logic [7:0] pick_key();
        int         r;
        logic [7:0] k;
        r = $urandom_range(0, 99);
        k = key_base + 8'($urandom_range(0, 23));
        if (r < 8)       return cfg_unknown;
        else if (r < 14) return cfg_broadcast;
        else if (r < 20) return 8'($urandom_range(0, 255));
        else             return k;
    endfunction

    // Fill the table from empty, then mix random operations over a small key pool
    task automatic run_random(int count);
        knt_pkg::t_req rq;
        knt_pkg::t_req prev;
        int            n;
        logic [7:0]    k;
        prev = '0;
        queue_req(knt_pkg::FN_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        for (n = 0; n < DEPTH + 2; n++) begin
            k = key_base + 8'(n);
            queue_req(knt_pkg::FN_SET_ALL, k, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
        for (n = 0; n < count - DEPTH - 3; n++) begin
            if ($urandom_range(0, 99) < 15) begin
                rq = prev;
            end else begin
                rq.func       = pick_func();
                rq.node_key   = pick_key();
                rq.profile_in = 8'($urandom_range(0, 255));
                rq.major_in   = 8'($urandom_range(0, 255));
                rq.minor_in   = 8'($urandom_range(0, 255));
                rq.patch_in   = 8'($urandom_range(0, 255));
            end
            req_pending = {req_pending, rq};
            prev = rq;
        end
    endtask

    initial begin
        int         ph;
        logic [7:0] unk;
        logic [7:0] bcast;
        logic [7:0] fb;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        tbl_fill      = 0;
        cfg_unknown   = knt_pkg::UNKNOWN_ID_RST;
        cfg_broadcast = knt_pkg::BROADCAST_ID_RST;
        cfg_fallback  = knt_pkg::FALLBACK_RST;
        key_base      = 8'h10;
        mismatches    = 0;
        cycle_count   = 0;
        req_gap       = 0;
        rsp_stall     = 0;
        req_calm      = 1'b0;
        rsp_calm      = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_req(knt_pkg::FN_LOOKUP,   8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_req(knt_pkg::FN_REMOVE,   8'h10, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_req(knt_pkg::FN_SET_ALL,  8'h00, 8'h11, 8'h22, 8'h33, 8'h44);
        queue_req(knt_pkg::FN_SET_VER,  8'hFF, 8'h11, 8'h22, 8'h33, 8'h44);
        queue_req(knt_pkg::FN_SET_ALL,  8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_req(knt_pkg::FN_SET_ALL,  8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_req(knt_pkg::FN_SET_PROF, 8'h10, 8'h00, 8'h01, 8'h02, 8'h03);
        queue_req(knt_pkg::FN_SET_PROF, 8'h10, 8'h00, 8'h04, 8'h05, 8'h06);
        queue_req(knt_pkg::FN_SET_VER,  8'h10, 8'h77, 8'h00, 8'h00, 8'h00);
        queue_req(knt_pkg::FN_SET_VER,  8'h10, 8'h88, 8'h00, 8'h00, 8'h00);
        queue_req(knt_pkg::FN_SET_PROF, 8'h20, 8'hA5, 8'hFF, 8'hFF, 8'hFF);
        queue_req(knt_pkg::FN_SET_VER,  8'h30, 8'hFF, 8'h12, 8'h34, 8'h56);
        queue_req(knt_pkg::FN_LOOKUP,   8'h20, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_req(knt_pkg::FN_LOOKUP,   8'h30, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_req(knt_pkg::FN_LOOKUP,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_req(FN_SPARE_6,           8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_req(FN_SPARE_7,           8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_req(knt_pkg::FN_REMOVE,   8'h20, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_req(knt_pkg::FN_LOOKUP,   8'h30, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_req(knt_pkg::FN_CLEAR,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_req(knt_pkg::FN_LOOKUP,   8'h10, 8'h00, 8'h00, 8'h00, 8'h00);

        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            key_base = 8'($urandom_range(0, 255));
            unk      = 8'($urandom_range(0, 255));
            bcast    = 8'($urandom_range(0, 255));
            fb       = 8'($urandom_range(0, 255));
            case (ph)
                0: begin unk = 8'h00; bcast = 8'hFF; fb = 8'h00; end
                1: begin unk = 8'hFF; bcast = 8'h00; fb = 8'hFF; end
                3: begin unk = key_base + 8'd3; bcast = key_base + 8'd3; fb = 8'hA5; end
                5: begin unk = key_base + 8'd1; bcast = key_base + 8'd20; end
                default: ;
            endcase
            write_reg(knt_pkg::CFG_UNKNOWN_ID, unk);
            write_reg(knt_pkg::CFG_BROADCAST_ID, bcast);
            write_reg(knt_pkg::CFG_FALLBACK, fb);
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            run_random(240);
        end

        wait_idle();
        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && rsp_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
